// ===== hdl/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types, constants and codes of the crop bilinear downscaler.
// ----------------------------------------------------------------------------
package cbd_pkg;

	localparam int MAX_LINE_DEF  = 4096;
	localparam int FRAC_BITS_DEF = 16;

	localparam int POS_W   = 28;
	localparam int STEP_W  = 24;
	localparam int COORD_W = 12;
	localparam int LW_W    = 14;
	localparam int SW_W    = 13;
	localparam int MAX_RES = 4;

	localparam logic [LW_W-1:0]    LINE_WIDTH_RST = 14'd5760;
	localparam logic [SW_W-1:0]    SRC_SIZE_RST   = 13'd2880;
	localparam logic [SW_W-1:0]    OUT_SIZE_RST   = 13'd720;
	localparam logic [STEP_W-1:0]  STEP_RST       = 24'd262144;
	localparam logic [13:0]        LINE_LIMIT     = 14'd8192;
	localparam logic [SW_W-1:0]    OUT_LIMIT      = 13'd4096;
	localparam logic [POS_W-1:0]   POS_MAX        = 28'hFFFFFFF;

	typedef enum logic [2:0] {
		REG_LINE_WIDTH = 3'd0,
		REG_SRC_WIDTH  = 3'd1,
		REG_SRC_HEIGHT = 3'd2,
		REG_OUT_WIDTH  = 3'd3,
		REG_OUT_HEIGHT = 3'd4,
		REG_X_STEP     = 3'd5,
		REG_Y_STEP     = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_COL,
		ST_MUL1,
		ST_MUL2,
		ST_EMIT,
		ST_ROW
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic take;       // latch input word, update store
		logic col_step;   // advance column position
		logic mul1;       // capture horizontal blends
		logic mul2;       // capture vertical blend
		logic emit;       // load output register
		logic row_step;   // advance row position
		logic end_item;   // commit column/row counters
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic in_win;     // output window may exist on this pixel
		logic col_more;   // column loop continues
		logic col_hit;    // current column position lands here
		logic room;       // fewer than four results so far
		logic line_end;   // word ends its line
		logic row_more;   // row loop continues
		logic out_busy;   // output register still holds a word
	} stat_t;

	function automatic logic [SW_W-1:0] cap_out(input logic [SW_W-1:0] v);
		return (v > OUT_LIMIT) ? OUT_LIMIT : v;
	endfunction

	function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] p,
			input logic [STEP_W-1:0] s);
		logic [POS_W:0] t;
		t = {1'b0, p} + {5'd0, s};
		return t[POS_W] ? POS_MAX : t[POS_W-1:0];
	endfunction

endpackage

// ===== hdl/cbd_stream_if.sv =====
// ----------------------------------------------------------------------------
// cbd_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface cbd_stream_if #(parameter type payload_t = logic [7:0]);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cbd_ram.sv =====
// ----------------------------------------------------------------------------
// cbd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module cbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== hdl/cbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbd_ctrl
// Sequencer: walks one input word through column, blend and row steps.
// ----------------------------------------------------------------------------
module cbd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cbd_pkg::stat_t stat,
	output cbd_pkg::cmd_t  cmd
);
	import cbd_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_LOAD;
			ST_LOAD: state_nx = stat.in_win ? ST_COL : ST_ROW;
			ST_COL: begin
				if (!stat.col_more)
					state_nx = ST_ROW;
				else if (stat.col_hit && stat.room)
					state_nx = ST_MUL1;
			end
			ST_MUL1: state_nx = ST_MUL2;
			ST_MUL2: state_nx = ST_EMIT;
			ST_EMIT: if (!stat.out_busy) state_nx = ST_COL;
			ST_ROW:  if (!stat.row_more && !stat.out_busy) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_LOAD: ;
			ST_COL:  cmd.col_step = stat.col_more && !(stat.col_hit && stat.room);
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_EMIT: begin
				cmd.emit     = !stat.out_busy;
				cmd.col_step = !stat.out_busy;
			end
			ST_ROW: begin
				cmd.row_step = stat.row_more;
				cmd.end_item = !stat.row_more && !stat.out_busy;
			end
			default: ;
		endcase
	end

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.take, cmd.mul1, cmd.mul2, cmd.row_step}) <= 1)
		else $error("conflicting commands");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == ST_LOAD)
		else $error("take without load");
	a_mul_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul1 |=> cmd.mul2)
		else $error("blend sequence broken");
endmodule

// ===== hdl/cbd_datapath.sv =====
// ----------------------------------------------------------------------------
// cbd_datapath
// Positions, counters, line store, blend multipliers and output register.
// ----------------------------------------------------------------------------
module cbd_datapath #(
	parameter int MAX_LINE  = cbd_pkg::MAX_LINE_DEF,
	parameter int FRAC_BITS = cbd_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cbd_pkg::cmd_t                cmd,
	output cbd_pkg::stat_t               stat,
	input  logic [7:0]                   in_pixel,
	input  logic                         in_frame_start,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [31:0]                  cfg_data,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [7:0]                   out_pixel,
	output logic [cbd_pkg::COORD_W-1:0]  out_x,
	output logic [cbd_pkg::COORD_W-1:0]  out_y,
	output logic                         out_last,
	output logic                         out_done
);
	import cbd_pkg::*;

	localparam int AW = $clog2(MAX_LINE);
	localparam int FW = FRAC_BITS;
	localparam int IW = POS_W - FW;
	localparam logic [FW:0] ONE = {1'b1, {FW{1'b0}}};

	logic [LW_W-1:0]   line_width_q;
	logic [SW_W-1:0]   src_width_q, src_height_q, out_width_q, out_height_q;
	logic [STEP_W-1:0] x_step_q, y_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			src_width_q  <= SRC_SIZE_RST;
			src_height_q <= SRC_SIZE_RST;
			out_width_q  <= OUT_SIZE_RST;
			out_height_q <= OUT_SIZE_RST;
			x_step_q     <= STEP_RST;
			y_step_q     <= STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_WIDTH: line_width_q <= cfg_data[LW_W-1:0];
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SW_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SW_W-1:0];
				REG_OUT_WIDTH:  out_width_q  <= cfg_data[SW_W-1:0];
				REG_OUT_HEIGHT: out_height_q <= cfg_data[SW_W-1:0];
				REG_X_STEP:     x_step_q     <= cfg_data[STEP_W-1:0];
				REG_Y_STEP:     y_step_q     <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Derived sizes.
	logic [SW_W:0] kw, ow, oh, lw;
	always_comb begin
		kw = ({1'b0, src_width_q} < (SW_W+1)'(MAX_LINE)) ? {1'b0, src_width_q}
			: (SW_W+1)'(MAX_LINE);
		ow = {1'b0, cap_out(out_width_q)};
		oh = {1'b0, cap_out(out_height_q)};
		if (line_width_q == '0)
			lw = (SW_W+1)'(1);
		else if (line_width_q > LINE_LIMIT)
			lw = LINE_LIMIT;
		else
			lw = line_width_q;
	end

	// Counters and positions.
	logic [SW_W:0]      col_cnt_q;
	logic [COORD_W-1:0] row_cnt_q;
	logic [SW_W:0]      nxt_col_q, nxt_row_q;
	logic [POS_W-1:0]   col_pos_q, row_pos_q;
	logic [7:0]         left_q, upleft_q, pix_q, up_q;
	logic               kept_q;
	logic               take_s1;
	logic [7:0]         up;
	logic [2:0]         n_q;
	logic               ovalid_q;

	logic [IW-1:0] ix_raw, iy_raw;
	logic [SW_W:0] ix, iy, xlim, ylim;
	always_comb begin
		ix_raw = col_pos_q[POS_W-1:FW];
		iy_raw = row_pos_q[POS_W-1:FW];
		xlim = (kw >= (SW_W+1)'(2)) ? kw - (SW_W+1)'(2) : '0;
		ylim = ({1'b0, src_height_q} >= (SW_W+1)'(2))
			? {1'b0, src_height_q} - (SW_W+1)'(2) : '0;
		ix = ({{(SW_W+1){1'b0}}, ix_raw} > {{IW{1'b0}}, xlim}) ? xlim
			: (SW_W+1)'(ix_raw);
		iy = ({{(SW_W+1){1'b0}}, iy_raw} > {{IW{1'b0}}, ylim}) ? ylim
			: (SW_W+1)'(iy_raw);
	end

	// Effective counters this word (frame_start clears them first).
	always_comb begin
		stat.in_win   = kept_q && col_cnt_q >= (SW_W+1)'(1) && row_cnt_q != '0
			&& nxt_row_q < oh && iy + (SW_W+1)'(1) == {2'b0, row_cnt_q};
		stat.col_more = nxt_col_q < ow && ix + (SW_W+1)'(1) <= col_cnt_q;
		stat.col_hit  = ix + (SW_W+1)'(1) == col_cnt_q;
		stat.room     = n_q < 3'(MAX_RES);
		stat.line_end = col_cnt_q + (SW_W+1)'(1) >= lw;
		stat.row_more = stat.line_end && nxt_row_q < oh
			&& iy + (SW_W+1)'(1) <= {2'b0, row_cnt_q};
		stat.out_busy = ovalid_q && !out_ready;
	end

	cbd_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_store (
		.clk(clk),
		.we(cmd.take && !in_frame_start ? col_cnt_q < kw
			: cmd.take && kw != '0),
		.addr(cmd.take && in_frame_start ? '0 : col_cnt_q[AW-1:0]),
		.wdata(in_pixel),
		.rdata(up)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			nxt_col_q <= '0;
			nxt_row_q <= '0;
			col_pos_q <= '0;
			row_pos_q <= '0;
			left_q    <= '0;
			upleft_q  <= '0;
			kept_q    <= 1'b0;
			n_q       <= '0;
			take_s1   <= 1'b0;
		end else begin
			take_s1 <= cmd.take;
			if (cmd.take) begin
				n_q <= '0;
				if (in_frame_start) begin
					col_cnt_q <= '0;
					row_cnt_q <= '0;
					nxt_col_q <= '0;
					nxt_row_q <= '0;
					col_pos_q <= '0;
					row_pos_q <= '0;
					kept_q    <= kw != '0;
				end else begin
					kept_q <= col_cnt_q < kw;
				end
			end
			if (cmd.col_step) begin
				nxt_col_q <= nxt_col_q + 1'b1;
				col_pos_q <= sat_add(col_pos_q, x_step_q);
			end
			if (cmd.emit)
				n_q <= n_q + 1'b1;
			if (cmd.row_step) begin
				nxt_row_q <= nxt_row_q + 1'b1;
				row_pos_q <= sat_add(row_pos_q, y_step_q);
			end
			if (cmd.end_item) begin
				if (kept_q) begin
					upleft_q <= up_q;
					left_q   <= pix_q;
				end
				if (stat.line_end) begin
					col_cnt_q <= '0;
					row_cnt_q <= row_cnt_q + 1'b1;
					nxt_col_q <= '0;
					col_pos_q <= '0;
				end else begin
					col_cnt_q <= col_cnt_q + 1'b1;
				end
			end
		end
	end

	// The store read lands in the cycle after the take; it is held here because
	// the store output follows the freshly written pixel afterwards.
	always_ff @(posedge clk) begin
		if (cmd.take)
			pix_q <= in_pixel;
		if (take_s1)
			up_q <= up;
	end

	// Blend: two stages of multiply.
	logic [FW-1:0]      fx, fy;
	logic [FW+8:0]      top_s1, bot_s1;
	logic [2*FW+9:0]    tot_s2;
	assign fx = col_pos_q[FW-1:0];
	assign fy = row_pos_q[FW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			top_s1 <= (FW+9)'(upleft_q * (ONE - {1'b0, fx}))
				+ (FW+9)'(up_q * fx);
			bot_s1 <= (FW+9)'(left_q * (ONE - {1'b0, fx}))
				+ (FW+9)'(pix_q * fx);
		end
		if (cmd.mul2)
			tot_s2 <= (2*FW+10)'(top_s1 * (ONE - {1'b0, fy}))
				+ (2*FW+10)'(bot_s1 * fy);
	end

	// Positions never move back, so the only further hit on this word is the
	// very next column position; the word is the last one unless it lands here
	// too and there is still room.
	logic [POS_W-1:0] peek_pos;
	logic [IW-1:0]    peek_raw;
	logic [SW_W:0]    peek_ix;
	logic             is_last;
	always_comb begin
		peek_pos = sat_add(col_pos_q, x_step_q);
		peek_raw = peek_pos[POS_W-1:FW];
		peek_ix  = ({{(SW_W+1){1'b0}}, peek_raw} > {{IW{1'b0}}, xlim}) ? xlim
			: (SW_W+1)'(peek_raw);
		is_last  = !(nxt_col_q + (SW_W+1)'(1) < ow && n_q + 3'd1 < 3'(MAX_RES)
			&& peek_ix + (SW_W+1)'(1) == col_cnt_q);
	end

	// Output register.
	logic [7:0]         opix_q;
	logic [COORD_W-1:0] ox_q, oy_q;
	logic               odone_q, olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready)
				ovalid_q <= 1'b0;
			if (cmd.emit)
				ovalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			opix_q  <= tot_s2[2*FW+7:2*FW];
			ox_q    <= nxt_col_q[COORD_W-1:0];
			oy_q    <= nxt_row_q[COORD_W-1:0];
			odone_q <= nxt_col_q == ow - 1'b1 && nxt_row_q == oh - 1'b1;
			olast_q <= is_last;
		end
	end

	assign out_valid = ovalid_q;
	assign out_pixel = opix_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_last  = olast_q;
	assign out_done  = odone_q;

	a_pos_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.col_step |=> col_pos_q >= $past(col_pos_q))
		else $error("column position moved back");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !stat.out_busy)
		else $error("output overwritten");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 3'(MAX_RES))
		else $error("too many results");
endmodule

// ===== hdl/crop_bilinear_downscaler_unit.sv =====
// ----------------------------------------------------------------------------
// crop_bilinear_downscaler_unit
// Streaming crop and bilinear downscaler for one 8-bit plane.
// ----------------------------------------------------------------------------
// With no output window on it, an input word passes the idle, load and row
// states. When one does, the column loop comes before the row state; each
// result passes the two blend states and the emit state, and a stalled output
// holds it. The line store read and the two registered blend multipliers set
// this pace. A first result that lands at once is valid after the emit state.
// arst_n clears counters, positions, state, settings and output valid; the
// line store, the blend registers and the output data are not cleared.
module crop_bilinear_downscaler_unit #(
	parameter int MAX_LINE  = cbd_pkg::MAX_LINE_DEF,
	parameter int FRAC_BITS = cbd_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cbd_stream_if.sink   in_ch,
	cbd_stream_if.sink   cfg,
	cbd_stream_if.source out_ch
);
	import cbd_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// The configuration channel is always ready; writes must come while idle, which the block itself does not enforce.
	assign cfg.ready = 1'b1;

	cbd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	cbd_datapath #(.MAX_LINE(MAX_LINE), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_pixel(in_ch.data[7:0]), .in_frame_start(in_ch.data[8]),
		.cfg_we(cfg.valid), .cfg_index(cfg.data[34:32]),
		.cfg_data(cfg.data[31:0]),
		.out_ready(out_ch.ready), .out_valid(out_ch.valid),
		.out_pixel(out_ch.data[7:0]), .out_x(out_ch.data[19:8]),
		.out_y(out_ch.data[31:20]), .out_last(out_ch.data[32]),
		.out_done(out_ch.data[33])
	);
endmodule

// ===== tb/sv/cbd_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_tb_pkg
// Word layouts of the pixel, register write and output channels.
// ----------------------------------------------------------------------------
package cbd_tb_pkg;

	import cbd_pkg::*;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] pixel;
	} pix_word_t;

	typedef struct packed {
		reg_idx_t    idx;
		logic [31:0] wdata;
	} cfg_word_t;

	typedef struct packed {
		logic               plane_done;
		logic               last_of_run;
		logic [COORD_W-1:0] out_y;
		logic [COORD_W-1:0] out_x;
		logic [7:0]         out_pixel;
	} out_word_t;

endpackage

// ===== tb/sv/cbd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbd_checker
// Watches the channels, predicts every output word and compares in order.
// ----------------------------------------------------------------------------
module cbd_checker (
	input  logic clk,
	input  logic arst_n,
	cbd_stream_if in_ch,
	cbd_stream_if cfg,
	cbd_stream_if out_ch,
	output int   fail_count,
	output int   pending
);

	import cbd_pkg::*;
	import cbd_tb_pkg::*;

	logic [13:0] line_w;
	logic [12:0] src_w, src_h, dst_w, dst_h;
	logic [23:0] step_x, step_y;

	logic [7:0]  line_mem [0:4095];
	int unsigned col_cnt, row_cnt, left_px, upleft_px;
	int unsigned out_col, col_pos, out_row, row_pos;

	out_word_t scaled_q[$];

	assign pending = scaled_q.size();

	function automatic int unsigned int_part(int unsigned pos, int unsigned size);
		int unsigned lim;
		int unsigned ip;
		lim = (size >= 2) ? size - 2 : 0;
		ip = pos >> 16;
		return (ip > lim) ? lim : ip;
	endfunction

	function automatic int unsigned pos_add(int unsigned pos, int unsigned st);
		longint unsigned s;
		s = longint'(pos) + st;
		return (s > 64'h0FFF_FFFF) ? 32'h0FFF_FFFF : int'(s);
	endfunction

	function automatic int unsigned size_cap(int unsigned v);
		return (v > 4096) ? 4096 : v;
	endfunction

	function automatic logic [7:0] mix(int unsigned p00, int unsigned p10,
			int unsigned p01, int unsigned p11, int unsigned fx, int unsigned fy);
		longint unsigned one, top, bot, tot;
		one = 64'd65536;
		top = p00 * (one - fx) + p10 * longint'(fx);
		bot = p01 * (one - fx) + p11 * longint'(fx);
		tot = top * (one - fy) + bot * longint'(fy);
		return tot[39:32];
	endfunction

	// Advances the scaler state by one pixel and queues the words it yields.
	function automatic void scale_pixel(logic [7:0] pix, logic fs);
		int unsigned c, r, kw, ow, oh, lw, up, ix, fy;
		int n;
		out_word_t w;
		n = 0;
		if (fs) begin
			col_cnt = 0; row_cnt = 0; out_col = 0; col_pos = 0;
			out_row = 0; row_pos = 0;
		end
		c = col_cnt;
		r = row_cnt;
		kw = (src_w < 4096) ? src_w : 4096;
		ow = size_cap(dst_w);
		oh = size_cap(dst_h);
		if (c < kw) begin
			up = line_mem[c];
			line_mem[c] = pix;
			if (c >= 1 && r >= 1 && out_row < oh && int_part(row_pos, src_h) + 1 == r) begin
				fy = row_pos & 32'hFFFF;
				while (out_col < ow) begin
					ix = int_part(col_pos, kw);
					if (ix + 1 > c)
						break;
					if (ix + 1 == c && n < MAX_RES) begin
						w.out_pixel = mix(upleft_px, up, left_px, pix, col_pos & 32'hFFFF, fy);
						w.out_x = out_col[11:0];
						w.out_y = out_row[11:0];
						w.last_of_run = 1'b0;
						w.plane_done = (out_col == ow - 1 && out_row == oh - 1);
						scaled_q.push_back(w);
						n++;
					end
					out_col++;
					col_pos = pos_add(col_pos, step_x);
				end
			end
			upleft_px = up;
			left_px = pix;
		end
		lw = (line_w == 0) ? 1 : line_w;
		if (lw > 8192)
			lw = 8192;
		if (c + 1 >= lw) begin
			col_cnt = 0;
			row_cnt = (r + 1) & 32'hFFF;
			out_col = 0;
			col_pos = 0;
			while (out_row < oh && int_part(row_pos, src_h) + 1 <= r) begin
				out_row++;
				row_pos = pos_add(row_pos, step_y);
			end
		end else begin
			col_cnt = c + 1;
		end
		if (n > 0)
			scaled_q[scaled_q.size() - 1].last_of_run = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t got, want;
		if (!arst_n) begin
			line_w <= LINE_WIDTH_RST;
			src_w <= SRC_SIZE_RST; src_h <= SRC_SIZE_RST;
			dst_w <= OUT_SIZE_RST; dst_h <= OUT_SIZE_RST;
			step_x <= STEP_RST; step_y <= STEP_RST;
			col_cnt = 0; row_cnt = 0; left_px = 0; upleft_px = 0;
			out_col = 0; col_pos = 0; out_row = 0; row_pos = 0;
			fail_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.data.idx)
					REG_LINE_WIDTH: line_w <= cfg.data.wdata[13:0];
					REG_SRC_WIDTH:  src_w <= cfg.data.wdata[12:0];
					REG_SRC_HEIGHT: src_h <= cfg.data.wdata[12:0];
					REG_OUT_WIDTH:  dst_w <= cfg.data.wdata[12:0];
					REG_OUT_HEIGHT: dst_h <= cfg.data.wdata[12:0];
					REG_X_STEP:     step_x <= cfg.data.wdata[23:0];
					REG_Y_STEP:     step_y <= cfg.data.wdata[23:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				scale_pixel(in_ch.data.pixel, in_ch.data.frame_start);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (scaled_q.size() == 0) begin
					$error("output word with nothing expected: %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = scaled_q.pop_front();
					if (got != want) begin
						fail_count <= fail_count + 1;
						if (got.out_pixel != want.out_pixel)
							$error("out_pixel expected %0d actual %0d", want.out_pixel, got.out_pixel);
						if (got.out_x != want.out_x)
							$error("out_x expected %0d actual %0d", want.out_x, got.out_x);
						if (got.out_y != want.out_y)
							$error("out_y expected %0d actual %0d", want.out_y, got.out_y);
						if (got.last_of_run != want.last_of_run)
							$error("last_of_run expected %0d actual %0d",
								want.last_of_run, got.last_of_run);
						if (got.plane_done != want.plane_done)
							$error("plane_done expected %0d actual %0d",
								want.plane_done, got.plane_done);
					end
				end
			end
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams image planes through the crop bilinear downscaler under several
// register settings and lets the checker compare every output word.
// ----------------------------------------------------------------------------
module testbench;

	import cbd_pkg::*;
	import cbd_tb_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycles;
	int   random_items;

	cbd_stream_if #(.payload_t(pix_word_t)) in_ch ();
	cbd_stream_if #(.payload_t(cfg_word_t)) cfg ();
	cbd_stream_if #(.payload_t(out_word_t)) out_ch ();

	crop_bilinear_downscaler_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.out_ch (out_ch)
	);

	cbd_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg),
		.out_ch     (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// The clock runs with a 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// A hung handshake must not stall the run forever.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver changes its stall style each time stall_age wraps: always ready,
	// a coin flip, or long stretches of backpressure with brief openings.
	int unsigned stall_mode;
	int unsigned stall_age;
	always @(negedge clk) begin
		if (stall_age == 0)
			stall_mode <= $urandom_range(0, 2);
		stall_age <= (stall_age + 1) % 64;
		case (stall_mode)
			0: out_ch.ready <= 1'b1;
			1: out_ch.ready <= $urandom_range(0, 1);
			default: out_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Writes one register; the caller lowers valid after the last write.
	task automatic write_reg(reg_idx_t idx, int value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= '{idx: idx, wdata: 32'(value)};
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Sends one word and returns once it has been accepted; valid stays high
	// so that a back-to-back word needs no lowering in between.
	task automatic send_pixel(logic [7:0] pix, logic fs);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= '{pixel: pix, frame_start: fs};
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Programs every register, streams one plane in random bursts or back to back,
	// then waits until the block has drained so the next settings can be written safely.
	task automatic run_plane(int lw, int sw, int sh, int ow, int oh, int xs, int ys,
			int count, bit random_px);
		int burst_left;
		int gap;
		int bursty;
		logic [7:0] pix;
		logic fs;
		burst_left = 0;
		bursty = $urandom_range(0, 3);
		write_reg(REG_LINE_WIDTH, lw);
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_OUT_WIDTH, ow);
		write_reg(REG_OUT_HEIGHT, oh);
		write_reg(REG_X_STEP, xs);
		write_reg(REG_Y_STEP, ys);
		@(negedge clk);
		cfg.valid <= 1'b0;
		for (int i = 0; i < count; i++) begin
			if (burst_left == 0 && bursty != 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					@(negedge clk);
					in_ch.valid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
			// Random planes sometimes restart in the middle as noise.
			fs = (i == 0) || (random_px && $urandom_range(0, 99) == 0);
			pix = random_px ? 8'($urandom_range(0, 255)) : (i[0] ? 8'd255 : 8'd0);
			send_pixel(pix, fs);
		end
		@(negedge clk);
		in_ch.valid <= 1'b0;
		// The block is idle again once it is ready for a new word and every
		// predicted output word has come out.
		wait (pending == 0 && in_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		int lw, sw, sh, ow, oh, xs, ys, n;
		cycles = 0;
		stall_mode = 0;
		stall_age = 0;
		random_items = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '{idx: REG_LINE_WIDTH, wdata: '0};
		out_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Smallest plane: a single 2x2 window with black and white pixels.
		run_plane(2, 2, 2, 1, 1, 24'h010000, 24'h010000, 4, 1'b0);
		// Step of exactly 1.0 on a 3x3 source: clamped positions repeat and
		// those outputs share the last window.
		run_plane(5, 3, 3, 3, 3, 24'h010000, 24'h010000, 15, 1'b0);
		// Degenerate sizes: zero line width and sources too small to blend.
		run_plane(0, 1, 8191, 2, 2, 24'h018000, 24'h018000, 4, 1'b1);
		// Steps below 1.0 crowd more than four outputs onto one pixel.
		run_plane(4, 4, 3, 9, 3, 24'h000000, 24'h004000, 12, 1'b1);
		// Largest output size with the widest step down the rows and a source
		// only two lines tall; the last column collects clamped positions.
		run_plane(20, 19, 2, 4096, 4096, 24'h010000, 24'hFFFFFF, 40, 1'b1);

		// Random small planes until about 210 words have gone through in all;
		// the fixed planes above send 75.
		while (random_items < 135) begin
			lw = $urandom_range(2, 10);
			sw = $urandom_range(2, lw + 2);
			sh = $urandom_range(2, 6);
			ow = ($urandom_range(0, 9) == 0) ? 5000 : $urandom_range(1, 6);
			oh = ($urandom_range(0, 9) == 0) ? 5000 : $urandom_range(1, 6);
			case ($urandom_range(0, 9))
				0: xs = 24'hFFFFFF;
				1: xs = $urandom_range(0, 65535);
				default: xs = 65536 + $urandom_range(0, 3 * 65536);
			endcase
			case ($urandom_range(0, 9))
				0: ys = 24'hFFFFFF;
				1: ys = $urandom_range(0, 65535);
				default: ys = 65536 + $urandom_range(0, 3 * 65536);
			endcase
			n = lw * sh + $urandom_range(0, lw);
			run_plane(lw, sw, sh, ow, oh, xs, ys, n, 1'b1);
			random_items += n;
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
